FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk, disabled while rst is high.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_AT(label, clk, rst, !(expr))

`endif

FILE: sv/ipv4hb_pkg.sv
`default_nettype none
package ipv4hb_pkg;

   localparam logic [3:0]  IPV4_VERSION       = 4'd4;
   localparam logic [16:0] FIXED_HEADER_BYTES = 17'd20;
   localparam logic [3:0]  MIN_HEADER_WORDS   = 4'd5;
   localparam logic [15:0] MAX_FRAME_RESET    = 16'd1500;
   localparam int          HEADER_WORD_COUNT  = 5;
   localparam int          REQ_DATA_BITS      = 144;
   localparam int          RSP_DATA_BITS      = 32;

   typedef logic [2:0] remain_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_SHORT_HEADER = 2'd1,
      STATUS_TOO_LARGE    = 2'd2
   } status_type;

   typedef struct packed {
      logic [3:0]  header_words;
      logic [7:0]  service_type;
      logic [15:0] ident;
      logic [15:0] fragment_field;
      logic [7:0]  time_to_live;
      logic [7:0]  proto_number;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] payload_bytes;
   } request_type;

   typedef logic [RSP_DATA_BITS-1:0] word_type;

   // Finished header for one request, as handed to the output stage.
   typedef struct packed {
      word_type [HEADER_WORD_COUNT-1:0] words;
      status_type                       status;
      logic                             single;
   } header_type;

endpackage
`default_nettype wire

FILE: sv/ipv4hb_hdr_calc.sv
`default_nettype none
module ipv4hb_hdr_calc (
   input  wire ipv4hb_pkg::request_type req,
   input  wire logic [15:0]             max_frame_bytes,
   output ipv4hb_pkg::header_type       hdr
);

   logic [16:0] total;
   logic [15:0] total_len;
   logic [19:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [31:0] word0;
   logic [31:0] word1;
   logic [31:0] word2_top;

   always_comb begin
      total     = {1'b0, req.payload_bytes} + ipv4hb_pkg::FIXED_HEADER_BYTES;
      total_len = total[15:0];
      word0     = {ipv4hb_pkg::IPV4_VERSION, req.header_words, req.service_type, total_len};
      word1     = {req.ident, req.fragment_field};
      word2_top = {req.time_to_live, req.proto_number, 16'h0000};

      // Ones' complement sum of the ten halfwords, checksum field at zero.
      sum = 20'(word0[31:16]) + 20'(word0[15:0])
          + 20'(word1[31:16]) + 20'(word1[15:0])
          + 20'(word2_top[31:16])
          + 20'(req.source_addr[31:16]) + 20'(req.source_addr[15:0])
          + 20'(req.dest_addr[31:16]) + 20'(req.dest_addr[15:0]);
      fold1 = {1'b0, sum[15:0]} + 17'(sum[19:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);

      hdr.words[0] = word0;
      hdr.words[1] = word1;
      hdr.words[2] = word2_top | {16'h0000, ~fold2};
      hdr.words[3] = req.source_addr;
      hdr.words[4] = req.dest_addr;
      hdr.status   = ipv4hb_pkg::STATUS_OK;
      hdr.single   = 1'b0;

      if (req.header_words < ipv4hb_pkg::MIN_HEADER_WORDS) begin
         hdr.status = ipv4hb_pkg::STATUS_SHORT_HEADER;
         hdr.single = 1'b1;
      end else if (total > {1'b0, max_frame_bytes}) begin
         hdr.status = ipv4hb_pkg::STATUS_TOO_LARGE;
         hdr.single = 1'b1;
      end
      if (hdr.single) begin
         hdr.words[0] = '0;
      end
   end

endmodule
`default_nettype wire

FILE: sv/ipv4hb_serializer.sv
`default_nettype none
module ipv4hb_serializer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   hdr_valid,
   input  wire ipv4hb_pkg::header_type hdr,
   output logic                        hdr_load,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [31:0]                 rsp_tdata,  // header_word
   output logic                        rsp_tlast,  // word_last
   output logic [1:0]                  rsp_tuser   // status
);

   localparam int N = ipv4hb_pkg::HEADER_WORD_COUNT;

   ipv4hb_pkg::word_type [N-1:0] words_ff, words_in;
   ipv4hb_pkg::remain_type       remain_ff, remain_in;
   ipv4hb_pkg::status_type       status_ff, status_in;
   logic                         busy_ff, busy_in;
   logic                         beat;
   logic                         last;

   always_comb begin
      last     = (remain_ff == ipv4hb_pkg::remain_type'(1));
      beat     = busy_ff && rsp_tready;
      hdr_load = hdr_valid && (!busy_ff || (beat && last));

      words_in  = words_ff;
      remain_in = remain_ff;
      status_in = status_ff;
      busy_in   = busy_ff;
      if (hdr_load) begin
         words_in  = hdr.words;
         remain_in = hdr.single ? ipv4hb_pkg::remain_type'(1) : ipv4hb_pkg::remain_type'(N);
         status_in = hdr.status;
         busy_in   = 1'b1;
      end else if (beat) begin
         // advance to the next header word
         for (int k = 0; k < N - 1; k++) begin
            words_in[k] = words_ff[k+1];
         end
         remain_in = remain_ff - ipv4hb_pkg::remain_type'(1);
         busy_in   = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         remain_ff <= '0;
      end else begin
         busy_ff   <= busy_in;
         remain_ff <= remain_in;
      end
      words_ff  <= words_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = words_ff[0];
   assign rsp_tlast  = last;
   assign rsp_tuser  = status_ff;

endmodule
`default_nettype wire

FILE: sv/ipv4_header_builder.sv
// IPv4 header builder. Each request on req_ yields either the five 32-bit words of the
// fixed 20-byte IPv4 header in network order (version 4, total length = payload + 20,
// header checksum filled in), or a single zero word with tlast set and an error code in
// tuser (1: header length below five words, 2: total size above the limit written
// through csr_, 1500 bytes after reset). A request is registered on entry, its header
// and checksum are formed in one pass, and it then moves into the output word register.
// The first word reaches rsp_ after the request register and the output word register.
// A new request is taken every cycle while the output stage can accept it; the 32-bit
// result channel bounds the sustained rate, as a valid request yields five words and
// a rejected request one.
`default_nettype none
module ipv4_header_builder (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data,  // max_frame_bytes
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // header_words, service_type, ident, fragment_field, time_to_live, proto_number,
   // source_addr, dest_addr, payload_bytes, then 4 zero bits
   input  wire logic [ipv4hb_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,    // header_word
   output logic              rsp_tlast,    // word_last
   output logic [1:0]        rsp_tuser     // status
);

   logic [15:0]             max_frame_ff;
   logic                    req_valid_ff, req_valid_in;
   ipv4hb_pkg::request_type req_ff, req_in;
   ipv4hb_pkg::header_type  hdr;
   logic                    hdr_load;
   logic                    req_fire;

   always_comb begin
      req_in.header_words   = req_tdata[3:0];
      req_in.service_type   = req_tdata[11:4];
      req_in.ident          = req_tdata[27:12];
      req_in.fragment_field = req_tdata[43:28];
      req_in.time_to_live   = req_tdata[51:44];
      req_in.proto_number   = req_tdata[59:52];
      req_in.source_addr    = req_tdata[91:60];
      req_in.dest_addr      = req_tdata[123:92];
      req_in.payload_bytes  = req_tdata[139:124];

      req_tready   = !req_valid_ff || hdr_load;
      req_fire     = req_tvalid && req_tready;
      req_valid_in = req_fire || (req_valid_ff && !hdr_load);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         max_frame_ff <= ipv4hb_pkg::MAX_FRAME_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         if (csr_wr_en) begin
            max_frame_ff <= csr_wr_data;
         end
      end
      if (req_fire) begin
         req_ff <= req_in;
      end
   end

   ipv4hb_hdr_calc u_calc (
      .req             (req_ff),
      .max_frame_bytes (max_frame_ff),
      .hdr             (hdr)
   );

   ipv4hb_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .hdr_valid  (req_valid_ff),
      .hdr        (hdr),
      .hdr_load   (hdr_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

FILE: sv/ipv4hb_checker.sv
`default_nettype none
`include "assert_macros.svh"
module ipv4hb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [1:0]  rsp_tuser
);

   logic        rsp_stall;
   logic        rsp_error;
   logic [34:0] rsp_item;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_error = rsp_tvalid && (rsp_tuser != ipv4hb_pkg::STATUS_OK);
   assign rsp_item  = {rsp_tdata, rsp_tlast, rsp_tuser};

   // A stalled result holds its item.
   `ASSERT_AT(rsp_hold_a, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_item))

   // An error is a lone zero word closing its request.
   `ASSERT_NEVER(err_single_a, clock, reset, rsp_error && (!rsp_tlast || (rsp_tdata != 32'h0)))

   // Only the words of a good header come before the last one.
   `ASSERT_NEVER(mid_status_a, clock, reset, rsp_error && !rsp_tlast)

   // A header does not pause in the middle on the block's side.
   `ASSERT_AT(no_gap_a, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)

endmodule

bind ipv4_header_builder ipv4hb_checker u_ipv4hb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
